### rtl/fbrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrd_pkg: shared types and constants of the row downscaler
// Box geometry constants, channel widths and the per-pixel control bundle
// handed from the box tracker to the channel lanes.
// ----------------------------------------------------------------------------
package fbrd_pkg;

   localparam int unsigned PIXEL_W   = 32;
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned NUM_CHAN  = 4;
   localparam int unsigned WEIGHT_W  = 25;
   localparam int unsigned SUM_W     = 32;
   localparam int unsigned BOX_SHIFT = 24;
   localparam int unsigned PROD_W    = CHAN_W + WEIGHT_W;

   // Weight of one complete destination box.
   localparam logic [WEIGHT_W-1:0] FULL_BOX = WEIGHT_W'(1) << BOX_SHIFT;

   // How the current pixel's weight lands relative to the open box.
   typedef enum logic [1:0] {
      FILL_PARTIAL,   // box stays open
      FILL_EXACT,     // box closes exactly on this pixel
      FILL_SPLIT      // box closes, remainder opens the next box
   } fill_mode_type;

   typedef struct packed {
      fill_mode_type       mode;
      logic                clear;     // row end: drop the open box afterwards
      logic [WEIGHT_W-1:0] box_left;  // weight still missing from the box
      logic [WEIGHT_W-1:0] weight;    // saturated pixel weight
   } lane_ctrl_type;

endpackage

### rtl/fbrd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrd_if: valid/ready channels of the row downscaler
// Source pixel channel, destination pixel channel and weight write channel.
// ----------------------------------------------------------------------------
interface fbrd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] src_pixel;
   logic        row_end;

   modport source (output valid, output src_pixel, output row_end, input ready);
   modport sink   (input valid, input src_pixel, input row_end, output ready);
endinterface

interface fbrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_pixel;

   modport source (output valid, output out_pixel, input ready);
   modport sink   (input valid, input out_pixel, output ready);
endinterface

interface fbrd_csr_if;
   logic        valid;
   logic        ready;
   logic [24:0] pixel_weight;

   modport source (output valid, output pixel_weight, input ready);
   modport sink   (input valid, input pixel_weight, output ready);
endinterface

### rtl/fractional_box_row_downscaler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_box_row_downscaler_core: horizontal area-average downscaler
// One ARGB source pixel in, zero or one averaged destination pixel out.
// ----------------------------------------------------------------------------
// Each source pixel carries the weight written on the csr channel (one
// destination box weighs 2^24, larger values saturate to 2^24). Pixels are
// accumulated per channel into the open box; a pixel that crosses a box
// boundary gives the missing weight to the old box and the remainder to the
// new one, and each closed box comes out as the four channel sums shifted
// right by 24. A pixel flagged row_end is processed normally and then the
// open box is dropped. The block sustains one pixel per clock while the
// output is not stalled: an input register feeds a combinational
// multiply-accumulate (two 8x25 products per channel) that updates the box
// state and loads the output register, so a result passes the input
// register and then the output register. The weight register may be
// written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module fractional_box_row_downscaler_core (
   input  logic          clock,
   input  logic          reset,
   fbrd_req_if.sink      req_ch,
   fbrd_rsp_if.source    rsp_ch,
   fbrd_csr_if.sink      csr_ch
);
   import fbrd_pkg::*;

   // Configuration.
   logic [WEIGHT_W-1:0] weight_ff, weight_in;

   // Input register.
   logic               in_valid_ff, in_valid_in;
   logic [PIXEL_W-1:0] pixel_ff;
   logic               last_ff;

   // Box state.
   logic [WEIGHT_W-1:0] box_left_ff, box_left_in;
   logic [SUM_W-1:0]    sum_ff [NUM_CHAN];
   logic [SUM_W-1:0]    sum_in [NUM_CHAN];

   // Output register.
   logic               out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0] out_pixel_ff, out_pixel_in;

   logic                advance;
   logic                emit;
   logic [WEIGHT_W-1:0] weight_sat;
   fill_mode_type       mode;
   lane_ctrl_type       lane_ctrl;
   logic [CHAN_W-1:0]   box_byte [NUM_CHAN];

   // Move the held pixel through the datapath whenever the output slot is
   // free or being emptied this cycle.
   assign advance = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   assign weight_in = (csr_ch.valid) ? csr_ch.pixel_weight : weight_ff;

   // Saturate the weight so that a pixel never spans more than two boxes.
   assign weight_sat = (weight_ff > FULL_BOX) ? FULL_BOX : weight_ff;

   always_comb begin
      priority if (weight_sat < box_left_ff) begin
         mode = FILL_PARTIAL;
      end else if (weight_sat == box_left_ff) begin
         mode = FILL_EXACT;
      end else begin
         mode = FILL_SPLIT;
      end
   end

   assign lane_ctrl = '{mode: mode, clear: last_ff, box_left: box_left_ff,
                        weight: weight_sat};

   genvar g;
   generate
      for (g = 0; g < NUM_CHAN; g++) begin : g_lane
         fbrd_lane u_lane (
            .chan     (pixel_ff[g*CHAN_W +: CHAN_W]),
            .sum      (sum_ff[g]),
            .ctrl     (lane_ctrl),
            .box_byte (box_byte[g]),
            .sum_next (sum_in[g])
         );
      end
   endgenerate

   // Remaining box weight after this pixel; a split leaves the remainder
   // in a fresh box, and row end always starts over with a full box.
   always_comb begin
      box_left_in = box_left_ff;
      if (advance) begin
         if (last_ff) begin
            box_left_in = FULL_BOX;
         end else begin
            unique case (mode)
               FILL_PARTIAL: box_left_in = box_left_ff - weight_sat;
               FILL_EXACT:   box_left_in = FULL_BOX;
               FILL_SPLIT:   box_left_in = FULL_BOX - (weight_sat - box_left_ff);
               default:      box_left_in = FULL_BOX;
            endcase
         end
      end
   end

   // A closed box produces one result transaction.
   assign emit = advance && (mode != FILL_PARTIAL);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_pixel_in = {box_byte[3], box_byte[2], box_byte[1], box_byte[0]};
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_pixel = out_pixel_ff;

   // Control state and box state.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= FULL_BOX;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         box_left_ff  <= FULL_BOX;
         for (int i = 0; i < NUM_CHAN; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         weight_ff    <= weight_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         box_left_ff  <= box_left_in;
         if (advance) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
               sum_ff[i] <= sum_in[i];
            end
         end
      end
   end

   // Payload registers: hold the pixel until it advances.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         pixel_ff <= req_ch.src_pixel;
         last_ff  <= req_ch.row_end;
      end
      out_pixel_ff <= out_pixel_in;
   end

   // The open box always misses some weight, never more than a full box.
   a_box_left_range: assert property (@(posedge clock) disable iff (reset)
      (box_left_ff != '0) && (box_left_ff <= FULL_BOX))
      else $error("box_left out of range");

   // A row end leaves an empty, full-weight box behind.
   a_row_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && last_ff) |=> (box_left_ff == FULL_BOX) && (sum_ff[0] == '0)
         && (sum_ff[1] == '0) && (sum_ff[2] == '0) && (sum_ff[3] == '0))
      else $error("row end did not clear the box");

   // Never overwrite a held pixel that has not advanced.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> (!in_valid_ff || advance))
      else $error("input register overrun");

   // Never load a result while the previous one is still stalled.
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!out_valid_ff || rsp_ch.ready))
      else $error("result dropped");

endmodule

### rtl/fbrd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrd_lane: weighted accumulate for one color channel
// Computes the byte of a closing box and the next running sum of the channel.
// ----------------------------------------------------------------------------
module fbrd_lane (
   input  logic [fbrd_pkg::CHAN_W-1:0] chan,
   input  logic [fbrd_pkg::SUM_W-1:0]  sum,
   input  fbrd_pkg::lane_ctrl_type     ctrl,
   output logic [fbrd_pkg::CHAN_W-1:0] box_byte,
   output logic [fbrd_pkg::SUM_W-1:0]  sum_next
);
   import fbrd_pkg::*;

   logic [PROD_W-1:0] prod_w;
   logic [PROD_W-1:0] prod_left;
   logic [SUM_W-1:0]  closed_sum;
   logic [SUM_W-1:0]  rest_sum;

   // Full pixel share and the share that still fits the open box.
   assign prod_w    = PROD_W'(chan) * PROD_W'(ctrl.weight);
   assign prod_left = PROD_W'(chan) * PROD_W'(ctrl.box_left);

   assign closed_sum = sum + prod_left[SUM_W-1:0];
   assign rest_sum   = prod_w[SUM_W-1:0] - prod_left[SUM_W-1:0];
   assign box_byte   = closed_sum[BOX_SHIFT +: CHAN_W];

   always_comb begin
      sum_next = '0;
      if (!ctrl.clear) begin
         unique case (ctrl.mode)
            FILL_PARTIAL: sum_next = sum + prod_w[SUM_W-1:0];
            FILL_EXACT:   sum_next = '0;
            FILL_SPLIT:   sum_next = rest_sum;
            default:      sum_next = '0;
         endcase
      end
   end

endmodule
